>>> rtl/bfcg_pkg.sv
// Shared types, constants and font tables of the bitmap font cell generator.
package bfcg_pkg;

  localparam int COORD_BITS  = 11;
  localparam int MAX_SCALE   = 8;
  localparam int GLYPH_COLS  = 3;
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_CELLS = GLYPH_COLS * GLYPH_ROWS;
  localparam int QUEUE_DEPTH = 2;
  localparam int CELL_IDX_W  = $clog2(GLYPH_CELLS);
  localparam int CASE_FOLD   = 32;
  localparam int NUM_DIGITS  = 10;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [GLYPH_CELLS-1:0] glyph_mask_t;
  typedef logic [3:0]             scale_t;
  typedef logic [CELL_IDX_W-1:0]  cell_idx_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_CELL_SCALE   = 3'd2,
    REG_CHAR_SPACING = 3'd3,
    REG_TEXT_COLOR   = 3'd4
  } reg_index_t;

  typedef struct packed {
    coord_t     origin_x;
    coord_t     origin_y;
    scale_t     scale;
    logic [3:0] spacing;
    logic [7:0] color;
  } cfg_t;

  typedef struct packed {
    glyph_mask_t mask;
    coord_t      pen;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } glyph_sel_t;

  typedef struct packed {
    logic [2:0] row;
    logic [1:0] col;
  } cell_pos_t;

  function automatic coord_t sat_coord(input logic [COORD_BITS:0] v);
    return v[COORD_BITS] ? '1 : v[COORD_BITS-1:0];
  endfunction

  function automatic glyph_sel_t code_to_glyph(input logic [7:0] code);
    glyph_sel_t g;
    logic [7:0] c;
    g = '0;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'(CASE_FOLD);
    if (c >= 8'h30 && c <= 8'h39) begin
      g.valid = 1'b1;
      g.idx   = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g.valid = 1'b1;
      g.idx   = 6'(c - 8'h41) + 6'(NUM_DIGITS);
    end
    return g;
  endfunction

  // rows top to bottom, bit 2 of each row is the leftmost column
  function automatic logic [GLYPH_CELLS-1:0] glyph_rows(input logic [5:0] idx);
    logic [GLYPH_CELLS-1:0] r;
    case (idx)
      6'd0:  r = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      6'd1:  r = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      6'd2:  r = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      6'd3:  r = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      6'd4:  r = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      6'd5:  r = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      6'd6:  r = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      6'd7:  r = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      6'd8:  r = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      6'd9:  r = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      6'd10: r = {3'd7, 3'd5, 3'd7, 3'd5, 3'd5};
      6'd11: r = {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      6'd12: r = {3'd7, 3'd4, 3'd4, 3'd4, 3'd7};
      6'd13: r = {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      6'd14: r = {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
      6'd15: r = {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
      6'd16: r = {3'd7, 3'd4, 3'd5, 3'd5, 3'd7};
      6'd17: r = {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      6'd18: r = {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
      6'd19: r = {3'd1, 3'd1, 3'd1, 3'd5, 3'd7};
      6'd20: r = {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      6'd21: r = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      6'd22: r = {3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
      6'd23: r = {3'd5, 3'd7, 3'd7, 3'd7, 3'd5};
      6'd24: r = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      6'd25: r = {3'd7, 3'd5, 3'd7, 3'd4, 3'd4};
      6'd26: r = {3'd7, 3'd5, 3'd5, 3'd7, 3'd3};
      6'd27: r = {3'd7, 3'd5, 3'd7, 3'd6, 3'd5};
      6'd28: r = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      6'd29: r = {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      6'd30: r = {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
      6'd31: r = {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
      6'd32: r = {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
      6'd33: r = {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      6'd34: r = {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      6'd35: r = {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cell_pos_t cell_pos(input cell_idx_t k);
    cell_pos_t p;
    p = '0;
    for (int i = 0; i < GLYPH_CELLS; i++) begin
      if (k == CELL_IDX_W'(i)) begin
        p.row = 3'(i / GLYPH_COLS);
        p.col = 2'(i % GLYPH_COLS);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/bitmap_font_cell_generator.sv
// Top level of the 3x5 bitmap font cell generator: configuration registers and block wiring.
// Characters enter through a queue-style port at up to one per cycle while the job queue has
// room; spaces and codes without a glyph only move the pen and use no back-end time. Each
// drawable character becomes a job that the cell emitter turns into one result per lit font
// cell, one per cycle while the consumer takes them, so a glyph with n lit cells (7 to 13)
// yields n results; back-to-back characters follow with no gap; the emitter sets the rate.
// From idle, a character passes a queue entry, job registers and the result register.
// Results come from a one-entry output register that refills in the cycle its result is taken;
// while the consumer stalls the emitter holds.
// Configuration must be written only while idle; the block itself does not enforce it.
module bitmap_font_cell_generator (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       char_code,
  input  logic             first_of_string,
  output logic             empty,
  input  logic             pop,
  output bfcg_pkg::coord_t cell_x,
  output bfcg_pkg::coord_t cell_y,
  output bfcg_pkg::scale_t cell_size,
  output logic [7:0]       cell_color,
  output logic             last_cell,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  bfcg_pkg::coord_t cfg_data
);
  import bfcg_pkg::*;

  coord_t     origin_x;
  coord_t     origin_y;
  scale_t     cell_scale;
  logic [3:0] char_spacing;
  logic [7:0] text_color;
  cfg_t       cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  job_t       wr_job;
  job_t       rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_scale   <= 4'd1;
      char_spacing <= 4'd1;
      text_color   <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_ORIGIN_X:     origin_x     <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[COORD_BITS-1:0];
        REG_CELL_SCALE:   cell_scale   <= cfg_data[3:0];
        REG_CHAR_SPACING: char_spacing <= cfg_data[3:0];
        REG_TEXT_COLOR:   text_color   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.spacing  = char_spacing;
    cfg.color    = text_color;
    if (cell_scale == '0) begin
      cfg.scale = 4'd1;
    end else if (cell_scale > 4'(MAX_SCALE)) begin
      cfg.scale = 4'(MAX_SCALE);
    end else begin
      cfg.scale = cell_scale;
    end
  end

  bfcg_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .char_code       (char_code),
    .first_of_string (first_of_string),
    .cfg             (cfg),
    .q_push          (q_push),
    .q_job           (wr_job),
    .q_full          (q_full)
  );

  bfcg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  bfcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_job      (rd_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_size  (cell_size),
    .cell_color (cell_color),
    .last_cell  (last_cell)
  );

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job queue written while full");

  a_no_queue_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("job queue read while empty");

  a_size_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cell_size != '0 && cell_size <= 4'(MAX_SCALE)))
    else $error("cell size out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result visible right after reset");

endmodule

>>> rtl/bfcg_front.sv
// Front end: accepts characters, keeps the pen, looks up the glyph and queues draw jobs.
module bfcg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_code,
  input  logic                 first_of_string,
  input  bfcg_pkg::cfg_t       cfg,
  output logic                 q_push,
  output bfcg_pkg::job_t       q_job,
  input  logic                 q_full
);
  import bfcg_pkg::*;

  coord_t                 pen_x;
  coord_t                 pen_x_next;
  coord_t                 base;
  logic                   accept;
  logic [5:0]             step;
  logic [COORD_BITS:0]    pen_sum;
  glyph_sel_t             glyph;
  logic [GLYPH_CELLS-1:0] rows;
  glyph_mask_t            mask;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    base    = first_of_string ? cfg.origin_x : pen_x;
    step    = 6'({cfg.scale, 1'b0}) + 6'(cfg.scale) + 6'(cfg.spacing);
    pen_sum = (COORD_BITS+1)'(base) + (COORD_BITS+1)'(step);
    pen_x_next = accept ? sat_coord(pen_sum) : pen_x;
    glyph = code_to_glyph(char_code);
    rows  = glyph_rows(glyph.idx);
    for (int k = 0; k < GLYPH_CELLS; k++) begin
      mask[k] = rows[GLYPH_CELLS-1-k];
    end
  end

  assign q_push     = accept && glyph.valid;
  assign q_job.mask = mask;
  assign q_job.pen  = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
    end else begin
      pen_x <= pen_x_next;
    end
  end

endmodule

>>> rtl/bfcg_queue.sv
// Short job queue between the front end and the cell emitter.
module bfcg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfcg_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output bfcg_pkg::job_t rd_job,
  output logic           empty
);
  import bfcg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> rtl/bfcg_back.sv
// Cell emitter: walks the lit cells of each queued glyph and drives the result register.
module bfcg_back (
  input  logic             clk,
  input  logic             rst,
  input  bfcg_pkg::cfg_t   cfg,
  input  bfcg_pkg::job_t   q_job,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output bfcg_pkg::coord_t cell_x,
  output bfcg_pkg::coord_t cell_y,
  output bfcg_pkg::scale_t cell_size,
  output logic [7:0]       cell_color,
  output logic             last_cell
);
  import bfcg_pkg::*;

  logic                active;
  glyph_mask_t         rem;
  coord_t              pen;
  logic                out_valid;
  cell_idx_t           k;
  cell_pos_t           pos;
  glyph_mask_t         onehot;
  glyph_mask_t         rem_clr;
  logic                last;
  logic                advance;
  logic                load;
  logic [COORD_BITS:0] x_sum;
  logic [COORD_BITS:0] y_sum;

  always_comb begin
    k = '0;
    for (int i = GLYPH_CELLS - 1; i >= 0; i--) begin
      if (rem[i]) k = CELL_IDX_W'(i);
    end
    pos     = cell_pos(k);
    onehot  = GLYPH_CELLS'(1) << k;
    rem_clr = rem & ~onehot;
    last    = (rem_clr == '0);
    x_sum   = (COORD_BITS+1)'(pen) + (COORD_BITS+1)'(6'(pos.col) * 6'(cfg.scale));
    y_sum   = (COORD_BITS+1)'(cfg.origin_y) + (COORD_BITS+1)'(7'(pos.row) * 7'(cfg.scale));
  end

  assign advance = active && (!out_valid || pop);
  assign load    = !active || (advance && last);
  assign q_pop   = load && !q_empty;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
      end else if (advance && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem <= q_job.mask;
      pen <= q_job.pen;
    end else if (advance) begin
      rem <= rem_clr;
    end
    if (advance) begin
      cell_x     <= sat_coord(x_sum);
      cell_y     <= sat_coord(y_sum);
      cell_size  <= cfg.scale;
      cell_color <= cfg.color;
      last_cell  <= last;
    end
  end

endmodule

>>> sim/bfcg_checker.sv
// Checker for the bitmap font cell generator: predicts lit cells per character and compares.
module bfcg_checker
  import bfcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] char_code,
  input  logic       first_of_string,
  input  logic       empty,
  input  logic       pop,
  input  coord_t     cell_x,
  input  coord_t     cell_y,
  input  scale_t     cell_size,
  input  logic [7:0] cell_color,
  input  logic       last_cell,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [10:0] cfg_data,
  output int         mismatches,
  output int         cells_due,
  output int         cells_checked,
  output int         glyphs_drawn
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_TOP  = (1 << COORD_BITS) - 1;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    scale_t     size;
    logic [7:0] color;
    logic       last;
  } lit_cell_t;

  lit_cell_t  cells_expected[$];
  coord_t     org_x;
  coord_t     org_y;
  scale_t     scale_reg;
  logic [3:0] spacing_reg;
  logic [7:0] color_reg;
  coord_t     pen;

  initial begin
    mismatches    = 0;
    cells_due     = 0;
    cells_checked = 0;
    glyphs_drawn  = 0;
  end

  // five rows of three bits as octal digits, top row first, bit 2 is the left column
  function automatic glyph_mask_t font_bits(input int g);
    case (g)
      0:  return 15'o75557;
      1:  return 15'o26227;
      2:  return 15'o71747;
      3:  return 15'o71717;
      4:  return 15'o55711;
      5:  return 15'o74717;
      6:  return 15'o74757;
      7:  return 15'o71111;
      8:  return 15'o75757;
      9:  return 15'o75717;
      10: return 15'o75755;
      11: return 15'o65656;
      12: return 15'o74447;
      13: return 15'o65556;
      14: return 15'o74647;
      15: return 15'o74644;
      16: return 15'o74557;
      17: return 15'o55755;
      18: return 15'o72227;
      19: return 15'o11157;
      20: return 15'o55655;
      21: return 15'o44447;
      22: return 15'o57755;
      23: return 15'o57775;
      24: return 15'o75557;
      25: return 15'o75744;
      26: return 15'o75573;
      27: return 15'o75765;
      28: return 15'o74717;
      29: return 15'o72222;
      30: return 15'o55557;
      31: return 15'o55552;
      32: return 15'o55775;
      33: return 15'o55255;
      34: return 15'o55222;
      35: return 15'o71247;
      default: return '0;
    endcase
  endfunction

  function automatic int clamp_coord(input int v);
    return (v > COORD_TOP) ? COORD_TOP : v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t MISMATCH: %s", $time, msg);
  endtask

  task automatic predict_cells(input logic [7:0] code, input logic first);
    int          s;
    int          g;
    int          n;
    int          lit;
    logic [7:0]  c;
    glyph_mask_t bits;
    lit_cell_t   exp_cell;
    s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg);
    if (first) pen = org_x;
    c = code;
    g = -1;
    if (c >= "a" && c <= "z") c = c - 8'(CASE_FOLD);
    if (c >= "0" && c <= "9") g = int'(c) - int'("0");
    else if (c >= "A" && c <= "Z") g = NUM_DIGITS + int'(c) - int'("A");
    if (g >= 0) begin
      bits = font_bits(g);
      lit = $countones(bits);
      n = 0;
      glyphs_drawn++;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int k = 0; k < GLYPH_COLS; k++) begin
          if (bits[GLYPH_CELLS - 1 - r * GLYPH_COLS - k]) begin
            exp_cell.x     = coord_t'(clamp_coord(int'(pen) + k * s));
            exp_cell.y     = coord_t'(clamp_coord(int'(org_y) + r * s));
            exp_cell.size  = scale_t'(s);
            exp_cell.color = color_reg;
            exp_cell.last  = (n == lit - 1);
            cells_expected.push_back(exp_cell);
            n++;
          end
        end
      end
    end
    pen = coord_t'(clamp_coord(int'(pen) + GLYPH_COLS * s + int'(spacing_reg)));
  endtask

  task automatic check_cell();
    lit_cell_t want;
    if (cells_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected cell x=%0d y=%0d", cell_x, cell_y));
      return;
    end
    want = cells_expected.pop_front();
    cells_checked++;
    if (cell_x !== want.x)
      report_mismatch($sformatf("cell_x %0d, expected %0d", cell_x, want.x));
    if (cell_y !== want.y)
      report_mismatch($sformatf("cell_y %0d, expected %0d", cell_y, want.y));
    if (cell_size !== want.size)
      report_mismatch($sformatf("cell_size %0d, expected %0d", cell_size, want.size));
    if (cell_color !== want.color)
      report_mismatch($sformatf("cell_color %0d, expected %0d", cell_color, want.color));
    if (last_cell !== want.last)
      report_mismatch($sformatf("last_cell %0b, expected %0b", last_cell, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      org_x       = '0;
      org_y       = '0;
      scale_reg   = 4'd1;
      spacing_reg = 4'd1;
      color_reg   = '0;
      pen         = '0;
      cells_expected.delete();
    end else begin
      if (pop && !empty) check_cell();
      if (push && !full) predict_cells(char_code, first_of_string);
      if (cfg_we) begin
        case (cfg_addr)
          REG_ORIGIN_X:     org_x = cfg_data;
          REG_ORIGIN_Y:     org_y = cfg_data;
          REG_CELL_SCALE:   scale_reg = cfg_data[3:0];
          REG_CHAR_SPACING: spacing_reg = cfg_data[3:0];
          REG_TEXT_COLOR:   color_reg = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    cells_due = cells_expected.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the bitmap font cell generator: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfcg_pkg::*;

  localparam realtime HALF_PERIOD   = 5ns;
  localparam int      RESET_CYCLES  = 7;
  localparam int      SETTLE_CYCLES = 32;
  localparam realtime RUN_LIMIT     = 5ms;
  localparam int      RANDOM_PHASES = 5;
  localparam int      PHASE_ITEMS   = 18;
  localparam logic [2:0] FIRST_UNUSED_REG = 3'(REG_TEXT_COLOR) + 3'd1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = '0;
  logic        first_of_string = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  coord_t      cell_x;
  coord_t      cell_y;
  scale_t      cell_size;
  logic [7:0]  cell_color;
  logic        last_cell;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [10:0] cfg_data = '0;

  int mismatches;
  int cells_due;
  int cells_checked;
  int glyphs_drawn;
  int items_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int pop_mode = 0;
  int pop_left = 0;

  always #(HALF_PERIOD) clk = ~clk;

  bitmap_font_cell_generator DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .char_code(char_code), .first_of_string(first_of_string),
    .empty(empty), .pop(pop),
    .cell_x(cell_x), .cell_y(cell_y), .cell_size(cell_size), .cell_color(cell_color),
    .last_cell(last_cell),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  bfcg_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .char_code(char_code), .first_of_string(first_of_string),
    .empty(empty), .pop(pop),
    .cell_x(cell_x), .cell_y(cell_y), .cell_size(cell_size), .cell_color(cell_color),
    .last_cell(last_cell),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .mismatches(mismatches), .cells_due(cells_due),
    .cells_checked(cells_checked), .glyphs_drawn(glyphs_drawn)
  );

  // receiver stall pattern: free-running, random, sparse and mostly-ready stretches
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_left = $urandom_range(5, 60);
      end else begin
        pop_left--;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_char(input logic [7:0] code, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    push            <= 1'b1;
    char_code       <= code;
    first_of_string <= first;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == 0);
  endtask

  function automatic logic [7:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return 8'("0" + $urandom_range(0, 9));
    if (sel < 60) return 8'("A" + $urandom_range(0, 25));
    if (sel < 78) return 8'("a" + $urandom_range(0, 25));
    if (sel < 86) return " ";
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed strings, some that continue without a start marker
  task automatic send_string();
    int  len;
    logic first;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
      send_char(pick_code(), first);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (cells_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [10:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_settings(input int ox, input int oy, input int sc, input int sp,
                                input int col);
    wait_idle();
    put_reg(REG_ORIGIN_X, 11'(ox));
    put_reg(REG_ORIGIN_Y, 11'(oy));
    put_reg(REG_CELL_SCALE, {7'($urandom), 4'(sc)});
    put_reg(REG_CHAR_SPACING, {7'($urandom), 4'(sp)});
    put_reg(REG_TEXT_COLOR, {3'($urandom), 8'(col)});
    // ignored index, must leave every register alone
    put_reg(FIRST_UNUSED_REG + 3'($urandom_range(0, 2)), 11'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_coord();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1900, 2047) : $urandom_range(0, 2047);
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings_used = 1;

    send_text("809AZaz @[`{/:");
    send_char(8'h00, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b1);
    send_char(8'hFF, 1'b0);

    write_settings(2047, 2047, 8, 15, 255);
    send_text("8W");
    write_settings(2040, 2030, 0, 0, 0);
    send_text("Bq");
    write_settings(1000, 500, 15, 7, 85);
    send_text("M3");
    write_settings(0, 0, 9, 15, 170);
    send_text("Xz");

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_settings(pick_coord(), pick_coord(),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                     $urandom_range(0, 15), $urandom_range(0, 255));
      for (int start = items_sent; items_sent - start < PHASE_ITEMS; ) begin
        send_string();
        if ($urandom_range(0, 9) == 0) begin
          push <= 1'b0;
          @(posedge clk);
          while (cells_due != 0) @(posedge clk);
        end
      end
    end

    wait_idle();
    $display("Sent %0d characters (%0d with glyphs) over %0d register settings.",
             items_sent, glyphs_drawn, settings_used);
    $display("Checked %0d lit cells, %0d mismatches.", cells_checked, mismatches);
    if (mismatches == 0 && cells_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d cells outstanding.", cells_due);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bfcg_pkg.sv
rtl/bfcg_front.sv
rtl/bfcg_queue.sv
rtl/bfcg_back.sv
rtl/bitmap_font_cell_generator.sv
sim/bfcg_checker.sv
sim/tb.sv
